// ----- src/bmods_pkg.sv -----
// ----------------------------------------------------------------------------
// bmods_pkg
// Shared constants, codes and types of the binary mask OR downsampler.
// ----------------------------------------------------------------------------
package bmods_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int IN_WIDTH_W     = 13;
   localparam int IN_HEIGHT_W    = 16;
   localparam int FACTOR_W       = 8;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int QUEUE_DEPTH    = 4;
   localparam int DIV_STEPS      = 16;
   localparam int DIV_STEP_W     = $clog2(DIV_STEPS);

   localparam logic [IN_WIDTH_W-1:0]  IN_WIDTH_RST  = 13'd4096;
   localparam logic [IN_HEIGHT_W-1:0] IN_HEIGHT_RST = 16'd4096;
   localparam logic [FACTOR_W-1:0]    FACTOR_RST    = 8'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IN_WIDTH  = 2'd0,
      CSR_IN_HEIGHT = 2'd1,
      CSR_FACTOR    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      LIM_LOAD,
      LIM_DIV,
      LIM_MUL,
      LIM_READY
   } lim_state_type;

   typedef struct packed {
      logic                   ready;
      logic [IN_WIDTH_W-1:0]  w_eff;
      logic [IN_HEIGHT_W-1:0] h_eff;
      logic [FACTOR_W-1:0]    f_m1;
      logic [IN_WIDTH_W-1:0]  ow;
      logic [IN_HEIGHT_W-1:0] ohf;
   } lim_type;

   typedef struct packed {
      logic first;
      logic pix;
      logic emit;
      logic row_end;
      logic image_end;
   } flags_type;

   typedef struct packed {
      logic out_pixel;
      logic row_end;
      logic image_end;
   } rsp_type;

endpackage

// ----- src/bmods_ram.sv -----
// ----------------------------------------------------------------------------
// bmods_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bmods_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/bmods_queue.sv -----
// ----------------------------------------------------------------------------
// bmods_queue
// Small first-in first-out queue in flip-flops.
// ----------------------------------------------------------------------------
module bmods_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == NW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- src/bmods_limits.sv -----
// ----------------------------------------------------------------------------
// bmods_limits
// Configuration registers and derived frame limits (output width and the
// height covered by whole blocks), found by a two-lane serial divider.
// ----------------------------------------------------------------------------
module bmods_limits
   import bmods_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output lim_type                lim
);

   logic [IN_WIDTH_W-1:0]  in_width_ff, in_width_in;
   logic [IN_HEIGHT_W-1:0] in_height_ff, in_height_in;
   logic [FACTOR_W-1:0]    factor_ff, factor_in;

   lim_state_type          state_ff, state_in;
   logic                   load_en, div_en, mul_en, ready;

   logic [IN_WIDTH_W-1:0]  w_eff;
   logic [IN_HEIGHT_W-1:0] h_eff;
   logic [FACTOR_W-1:0]    f_eff;

   logic [DIV_STEP_W-1:0]  step_ff, step_in;
   logic [DIV_STEPS-1:0]   quo_w_ff, quo_w_in, quo_h_ff, quo_h_in;
   logic [FACTOR_W-1:0]    rem_w_ff, rem_w_in, rem_h_ff, rem_h_in;
   logic [FACTOR_W-1:0]    f_div_ff, f_div_in;
   logic [IN_WIDTH_W-1:0]  ow_ff, ow_in;
   logic [IN_HEIGHT_W-1:0] ohf_ff, ohf_in;

   logic [FACTOR_W:0]            trial_w, trial_h;
   logic                         ge_w, ge_h;
   logic [DIV_STEPS+FACTOR_W-1:0] prod;

   // register writes
   always_comb begin
      in_width_in  = in_width_ff;
      in_height_in = in_height_ff;
      factor_in    = factor_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IN_WIDTH:  in_width_in  = csr_wdata[IN_WIDTH_W-1:0];
            CSR_IN_HEIGHT: in_height_in = csr_wdata[IN_HEIGHT_W-1:0];
            CSR_FACTOR:    factor_in    = csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= IN_WIDTH_RST;
         in_height_ff <= IN_HEIGHT_RST;
         factor_ff    <= FACTOR_RST;
      end else begin
         in_width_ff  <= in_width_in;
         in_height_ff <= in_height_in;
         factor_ff    <= factor_in;
      end
   end

   // clamp to legal limits
   always_comb begin
      if (in_width_ff == '0) begin
         w_eff = IN_WIDTH_W'(1);
      end else if (32'(in_width_ff) > MAX_WIDTH) begin
         w_eff = IN_WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = in_width_ff;
      end
      h_eff = (in_height_ff == '0) ? IN_HEIGHT_W'(1) : in_height_ff;
      f_eff = (factor_ff == '0) ? FACTOR_W'(1) : factor_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = LIM_LOAD;
      end else begin
         unique case (state_ff)
            LIM_LOAD:  state_in = LIM_DIV;
            LIM_DIV:   state_in = (step_ff == DIV_STEP_W'(DIV_STEPS - 1)) ? LIM_MUL : LIM_DIV;
            LIM_MUL:   state_in = LIM_READY;
            LIM_READY: state_in = LIM_READY;
            default:   state_in = LIM_LOAD;
         endcase
      end
   end

   // state outputs
   always_comb begin
      load_en = 1'b0;
      div_en  = 1'b0;
      mul_en  = 1'b0;
      ready   = 1'b0;
      unique case (state_ff)
         LIM_LOAD:  load_en = 1'b1;
         LIM_DIV:   div_en  = 1'b1;
         LIM_MUL:   mul_en  = 1'b1;
         LIM_READY: ready   = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LIM_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // restoring division, one quotient bit per cycle on both lanes
   assign trial_w = {rem_w_ff, quo_w_ff[DIV_STEPS-1]};
   assign trial_h = {rem_h_ff, quo_h_ff[DIV_STEPS-1]};
   assign ge_w    = (trial_w >= {1'b0, f_div_ff});
   assign ge_h    = (trial_h >= {1'b0, f_div_ff});
   assign prod    = quo_h_ff * f_div_ff;

   always_comb begin
      step_in  = step_ff;
      quo_w_in = quo_w_ff;
      quo_h_in = quo_h_ff;
      rem_w_in = rem_w_ff;
      rem_h_in = rem_h_ff;
      f_div_in = f_div_ff;
      ow_in    = ow_ff;
      ohf_in   = ohf_ff;
      if (load_en) begin
         step_in  = '0;
         quo_w_in = DIV_STEPS'(w_eff);
         quo_h_in = DIV_STEPS'(h_eff);
         rem_w_in = '0;
         rem_h_in = '0;
         f_div_in = f_eff;
      end
      if (div_en) begin
         step_in  = step_ff + DIV_STEP_W'(1);
         quo_w_in = {quo_w_ff[DIV_STEPS-2:0], ge_w};
         quo_h_in = {quo_h_ff[DIV_STEPS-2:0], ge_h};
         rem_w_in = ge_w ? FACTOR_W'(trial_w - {1'b0, f_div_ff}) : trial_w[FACTOR_W-1:0];
         rem_h_in = ge_h ? FACTOR_W'(trial_h - {1'b0, f_div_ff}) : trial_h[FACTOR_W-1:0];
      end
      if (mul_en) begin
         ow_in  = quo_w_ff[IN_WIDTH_W-1:0];
         ohf_in = prod[IN_HEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      quo_w_ff <= quo_w_in;
      quo_h_ff <= quo_h_in;
      rem_w_ff <= rem_w_in;
      rem_h_ff <= rem_h_in;
      f_div_ff <= f_div_in;
      ow_ff    <= ow_in;
      ohf_ff   <= ohf_in;
   end

   assign lim.ready = ready;
   assign lim.w_eff = w_eff;
   assign lim.h_eff = h_eff;
   assign lim.f_m1  = f_eff - FACTOR_W'(1);
   assign lim.ow    = ow_ff;
   assign lim.ohf   = ohf_ff;

   a_write_reloads: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (state_ff == LIM_LOAD))
      else $error("configuration write did not restart the limit calculation");

   a_ow_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == LIM_READY) |-> (32'(ow_ff) * 32'(f_eff) <= 32'(w_eff)))
      else $error("output width exceeds input width");

   a_ohf_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == LIM_READY) |-> (ohf_ff <= h_eff))
      else $error("block rows exceed input height");

endmodule

// ----- src/bmods_front.sv -----
// ----------------------------------------------------------------------------
// bmods_front
// Accepts pixel requests, tracks raster position and classifies each pixel
// (block start, block end with result, row and image end).
// ----------------------------------------------------------------------------
module bmods_front
   import bmods_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lim_type                      lim,
   input  logic                         push,
   output logic                         full,
   input  logic                         pixel,
   input  logic                         inq_full,
   output logic                         inq_push,
   output logic [$clog2(MAX_WIDTH)-1:0] inq_addr,
   output flags_type                    inq_flags
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int XW = (CW > IN_WIDTH_W) ? CW + 1 : IN_WIDTH_W + 1;

   logic [CW-1:0]          in_col_ff, in_col_in;
   logic [IN_HEIGHT_W-1:0] in_row_ff, in_row_in;
   logic [FACTOR_W-1:0]    cib_ff, cib_in;
   logic [FACTOR_W-1:0]    rib_ff, rib_in;
   logic [CW-1:0]          out_col_ff, out_col_in;

   logic accept, col_last, row_last, cib_done, rib_done, emit, row_end;

   assign full     = !lim.ready || inq_full;
   assign accept   = push && !full;

   assign col_last = XW'(in_col_ff) >= XW'(lim.w_eff - IN_WIDTH_W'(1));
   assign row_last = in_row_ff >= (lim.h_eff - IN_HEIGHT_W'(1));
   assign cib_done = cib_ff >= lim.f_m1;
   assign rib_done = rib_ff >= lim.f_m1;
   assign emit     = cib_done && rib_done && (XW'(out_col_ff) < XW'(lim.ow)) &&
                     (in_row_ff < lim.ohf);
   assign row_end  = (XW'(out_col_ff) + XW'(1)) == XW'(lim.ow);

   assign inq_push            = accept;
   assign inq_addr            = out_col_ff;
   assign inq_flags.first     = (rib_ff == '0) && (cib_ff == '0);
   assign inq_flags.pix       = pixel;
   assign inq_flags.emit      = emit;
   assign inq_flags.row_end   = row_end;
   assign inq_flags.image_end = row_end &&
                                (({1'b0, in_row_ff} + 17'd1) == {1'b0, lim.ohf});

   // advance raster position
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      cib_in     = cib_ff;
      rib_in     = rib_ff;
      out_col_in = out_col_ff;
      if (accept) begin
         if (col_last) begin
            in_col_in  = '0;
            cib_in     = '0;
            out_col_in = '0;
            if (row_last) begin
               in_row_in = '0;
               rib_in    = '0;
            end else begin
               in_row_in = in_row_ff + IN_HEIGHT_W'(1);
               rib_in    = rib_done ? '0 : rib_ff + FACTOR_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + CW'(1);
            if (cib_done) begin
               cib_in     = '0;
               out_col_in = out_col_ff + CW'(1);
            end else begin
               cib_in = cib_ff + FACTOR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         cib_ff     <= '0;
         rib_ff     <= '0;
         out_col_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         cib_ff     <= cib_in;
         rib_ff     <= rib_in;
         out_col_ff <= out_col_in;
      end
   end

endmodule

// ----- src/bmods_back.sv -----
// ----------------------------------------------------------------------------
// bmods_back
// Read-modify-write of the per-column OR accumulators and the result queue.
// ----------------------------------------------------------------------------
module bmods_back
   import bmods_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         inq_empty,
   input  logic [$clog2(MAX_WIDTH)-1:0] inq_addr,
   input  flags_type                    inq_flags,
   output logic                         inq_pop,
   output logic                         empty,
   input  logic                         pop,
   output rsp_type                      rsp
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic          s1_valid_ff, s1_valid_in;
   logic [CW-1:0] s1_addr_ff;
   flags_type     s1_flags_ff;
   logic          wr_valid_ff, wr_valid_in;
   logic [CW-1:0] wr_addr_ff;
   logic          wr_acc_ff;

   logic          s1_adv, ram_rdata, prev, acc;
   logic          outq_push, outq_full;
   rsp_type       outq_wdata;

   assign s1_adv  = s1_valid_ff && !(s1_flags_ff.emit && outq_full);
   assign inq_pop = !inq_empty && (!s1_valid_ff || s1_adv);

   bmods_ram #(
      .WIDTH (1),
      .DEPTH (MAX_WIDTH)
   ) u_acc_ram (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_addr_ff),
      .wdata (acc),
      .re    (inq_pop),
      .raddr (inq_addr),
      .rdata (ram_rdata)
   );

   // forward the latest write past the registered read
   assign prev = (wr_valid_ff && (wr_addr_ff == s1_addr_ff)) ? wr_acc_ff : ram_rdata;
   assign acc  = s1_flags_ff.first ? s1_flags_ff.pix : (prev | s1_flags_ff.pix);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (inq_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      wr_valid_in = wr_valid_ff || s1_adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         wr_valid_ff <= wr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (inq_pop) begin
         s1_addr_ff  <= inq_addr;
         s1_flags_ff <= inq_flags;
      end
      if (s1_adv) begin
         wr_addr_ff <= s1_addr_ff;
         wr_acc_ff  <= acc;
      end
   end

   assign outq_push            = s1_adv && s1_flags_ff.emit;
   assign outq_wdata.out_pixel = acc;
   assign outq_wdata.row_end   = s1_flags_ff.row_end;
   assign outq_wdata.image_end = s1_flags_ff.image_end;

   bmods_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (outq_push),
      .wdata (outq_wdata),
      .full  (outq_full),
      .pop   (pop),
      .rdata (rsp),
      .empty (empty)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      outq_push |-> !outq_full)
      else $error("result pushed into a full queue");

   a_result_visible: assert property (@(posedge clock) disable iff (reset)
      outq_push |=> !empty)
      else $error("pushed result not visible");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      inq_pop |-> !inq_empty)
      else $error("request popped from an empty queue");

endmodule

// ----- src/binary_mask_or_downsample.sv -----
// ----------------------------------------------------------------------------
// binary_mask_or_downsample
// A result reaches the rsp_ ports through the request queue, the registered
// accumulator read and the result queue. One pixel is accepted per cycle
// while full is low, using the accumulator RAM's one read and one write port.
// Reset clears the raster counters; full stays high after reset and after
// every configuration write while the serial divider finds the limits.
// Accumulator RAM is not cleared: each block's first pixel ignores the old value.
// ----------------------------------------------------------------------------
module binary_mask_or_downsample
   import bmods_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_pixel,
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_out_pixel,
   output logic                   rsp_row_end,
   output logic                   rsp_image_end,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int QW = CW + $bits(flags_type);

   lim_type       lim;
   logic          inq_push, inq_full, inq_pop, inq_empty;
   logic [CW-1:0] front_addr, back_addr;
   flags_type     front_flags, back_flags;
   logic [QW-1:0] inq_rdata;
   rsp_type       rsp;

   bmods_limits #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_limits (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .lim       (lim)
   );

   bmods_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .lim       (lim),
      .push      (push),
      .full      (full),
      .pixel     (req_pixel),
      .inq_full  (inq_full),
      .inq_push  (inq_push),
      .inq_addr  (front_addr),
      .inq_flags (front_flags)
   );

   bmods_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_req_queue (
      .clock (clock),
      .reset (reset),
      .push  (inq_push),
      .wdata ({front_addr, front_flags}),
      .full  (inq_full),
      .pop   (inq_pop),
      .rdata (inq_rdata),
      .empty (inq_empty)
   );

   assign back_addr  = inq_rdata[QW-1 -: CW];
   assign back_flags = inq_rdata[$bits(flags_type)-1:0];

   bmods_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .inq_empty (inq_empty),
      .inq_addr  (back_addr),
      .inq_flags (back_flags),
      .inq_pop   (inq_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_out_pixel = rsp.out_pixel;
   assign rsp_row_end   = rsp.row_end;
   assign rsp_image_end = rsp.image_end;

endmodule
